[design/gbl_pkg.sv]
package gbl_pkg;

    // defaults for the top-level parameters
    localparam int unsigned MAX_RADIUS_DEF = 7;
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned PIXEL_BITS_DEF = 16;

    localparam int unsigned TAP_BITS     = 16;
    localparam int unsigned TAP_IDX_BITS = 4;
    localparam int unsigned CFG_IDX_BITS = 3;

    // register reset values
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;
    localparam logic [2:0]  RADIUS_RST = 3'd3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_BLUR_RADIUS  = 3'd2,
        CFG_TAPS_LO      = 3'd3,
        CFG_TAPS_HI      = 3'd4
    } t_cfg_idx;

    // control that travels with one operand pair into the MAC
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    // pick tap k from the two 64-bit tap words; taps past seven read as zero
    function automatic logic [TAP_BITS-1:0] tap_sel(
        input logic [63:0]             taps_lo,
        input logic [63:0]             taps_hi,
        input logic [TAP_IDX_BITS-1:0] k
    );
        logic [TAP_BITS-1:0] t;
        if (k[3]) begin
            t = '0;
        end else if (k[2]) begin
            t = taps_hi[16*k[1:0] +: 16];
        end else begin
            t = taps_lo[16*k[1:0] +: 16];
        end
        return t;
    endfunction

endpackage

[design/separable_gaussian_blur_2d.sv]
// Separable Gaussian blur, vertical pass then horizontal, mirror boundaries.
// Pixels enter on the s_axis channel in raster order (tuser marks a flush
// item); blurred pixels leave on m_axis, tlast on the last pixel of a frame.
// Registers are written on the cfg channel (always ready); the host must write
// them only while no pixel is in work, the block does not enforce it. Output
// pixel k appears after input item k + R*W + R; the host appends R*W + R flush
// items to drain a frame. An item that yields no result leaves s_axis_tready
// high. An item that yields one keeps s_axis_tready low until its result is
// in the output register: one shared multiply-accumulate takes one tap per
// cycle, first (2R+1) vertical sums of 2R+1 row-store reads each, then one
// horizontal sum over those, and the row store has a single read port.
// The result sits in an output register; a stalled receiver holds it and the
// next result waits in the sequencer until the register frees.
// Reset (synchronous, active low) restores the register defaults and clears
// the frame counters; the row store is not cleared and needs no sweep.
module separable_gaussian_blur_2d #(
    parameter int unsigned MAX_RADIUS = gbl_pkg::MAX_RADIUS_DEF,
    parameter int unsigned MAX_WIDTH  = gbl_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = gbl_pkg::PIXEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: pixel_value
    input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: is_padding
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: blurred_pixel
    output logic [((PIXEL_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbl_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);
    import gbl_pkg::*;

    localparam int unsigned TDW   = ((PIXEL_BITS+7)/8)*8;
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned WCW   = CW + 1;
    localparam int unsigned RB    = $clog2(MAX_RADIUS+1);
    localparam int unsigned DB    = RB + 1;
    localparam int unsigned RING  = 2*MAX_RADIUS + 2;
    localparam int unsigned SB    = $clog2(RING);
    localparam int unsigned WIN   = 2*MAX_RADIUS + 1;
    localparam int unsigned WIB   = $clog2(WIN);
    localparam int unsigned AW    = SB + CW;
    localparam int unsigned DEPTH = RING << CW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_VERT   = 6'b000010,
        S_VDRAIN = 6'b000100,
        S_HORZ   = 6'b001000,
        S_HDRAIN = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    // mirror an index into 0..n-1 without repeating the edge
    function automatic logic signed [19:0] mirror(
        input logic signed [19:0] i,
        input logic signed [19:0] n
    );
        logic signed [19:0] m;
        m = i;
        if (m < 0) m = -m;
        if (m > n - 20'sd1) m = (n - 20'sd1) + (n - 20'sd1) - m;
        if (m < 0) m = 20'sd0;
        if (m > n - 20'sd1) m = n - 20'sd1;
        return m;
    endfunction

    t_state r_state;

    // configuration registers
    logic [10:0] r_cfg_w;
    logic [15:0] r_cfg_h;
    logic [2:0]  r_cfg_r;
    logic [63:0] r_taps_lo;
    logic [63:0] r_taps_hi;

    logic [WCW-1:0] w_eff;
    logic [15:0]    h_eff;
    logic [RB-1:0]  r_eff;
    logic [31:0]    lag;
    logic [31:0]    wh;
    logic [31:0]    o_idx;
    logic           emit;
    logic           fe;
    logic           acc_in;

    // frame counters
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [SB-1:0] r_wslot;
    logic [31:0]   r_items;
    logic [CW-1:0] r_ox;
    logic [15:0]   r_oy;
    logic [SB-1:0] r_oslot;

    // working copy for the pixel in work
    logic [CW-1:0] r_cx;
    logic [15:0]   r_cy;
    logic [SB-1:0] r_cslot;
    logic          r_fe;

    logic signed [DB-1:0] r_dx;
    logic signed [DB-1:0] r_dy;
    logic signed [DB-1:0] neg_r;
    logic signed [DB-1:0] pos_r;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rd_data;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [PIXEL_BITS-1:0] wr_pix;

    logic [PIXEL_BITS-1:0] r_win [WIN];
    logic [PIXEL_BITS-1:0] r_p_win;
    logic                  r_p_h;
    logic [WIB-1:0]        r_p_idx;
    logic [TAP_BITS-1:0]   r_p_tap;
    t_mac_ctl              r_p;
    logic                  r_q_h;
    logic [WIB-1:0]        r_q_idx;

    logic [PIXEL_BITS-1:0] r_res;
    logic                  r_ovld;
    logic [PIXEL_BITS-1:0] r_odata;
    logic                  r_olast;

    logic                  mac_done;
    logic [PIXEL_BITS-1:0] mac_sum;
    logic [PIXEL_BITS-1:0] mac_data;

    logic signed [19:0]    xi;
    logic signed [19:0]    yi;
    logic signed [19:0]    cxm;
    logic signed [19:0]    rym;
    logic signed [19:0]    dyr;
    logic signed [SB+1:0]  slot_s;
    logic [DB-1:0]         dy_abs;
    logic [DB-1:0]         dx_abs;
    logic signed [DB:0]    dx_off;
    logic                  issue_v;
    logic                  issue_h;
    logic                  pipe_idle;

    // clamp registers to their usable range
    always_comb begin
        if (r_cfg_w < 11'd8) begin
            w_eff = WCW'(8);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(r_cfg_w);
        end
        h_eff = (r_cfg_h < 16'd8) ? 16'd8 : r_cfg_h;
        if (r_cfg_r == 3'd0) begin
            r_eff = RB'(1);
        end else if (32'(r_cfg_r) > MAX_RADIUS) begin
            r_eff = RB'(MAX_RADIUS);
        end else begin
            r_eff = RB'(r_cfg_r);
        end
    end

    assign lag   = 32'(r_eff) * 32'(w_eff) + 32'(r_eff);
    assign wh    = 32'(w_eff) * 32'(h_eff);
    assign emit  = r_items >= lag;
    assign o_idx = r_items - lag;
    assign fe    = o_idx >= wh - 32'd1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= WIDTH_RST;
            r_cfg_h   <= HEIGHT_RST;
            r_cfg_r   <= RADIUS_RST;
            r_taps_lo <= '0;
            r_taps_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w   <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_cfg_h   <= i_cfg_data[15:0];
                CFG_BLUR_RADIUS:  r_cfg_r   <= i_cfg_data[2:0];
                CFG_TAPS_LO:      r_taps_lo <= i_cfg_data;
                CFG_TAPS_HI:      r_taps_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // row store write on each in-frame item
    assign wr_pix    = s_axis_tuser ? '0 : s_axis_tdata[PIXEL_BITS-1:0];
    assign mem_we    = acc_in && (r_row < h_eff);
    assign mem_waddr = {r_wslot, r_col};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= wr_pix;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // advance write and output positions; restart after the frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_wslot <= '0;
            r_items <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oslot <= '0;
        end else if (acc_in) begin
            if (emit && fe) begin
                r_col   <= '0;
                r_row   <= '0;
                r_wslot <= '0;
                r_items <= '0;
                r_ox    <= '0;
                r_oy    <= '0;
                r_oslot <= '0;
            end else begin
                if (r_row < h_eff) begin
                    if (WCW'(r_col) + WCW'(1) >= w_eff) begin
                        r_col   <= '0;
                        r_row   <= r_row + 16'd1;
                        r_wslot <= (32'(r_wslot) == RING - 1) ? '0 : r_wslot + SB'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                if (r_items != '1) begin
                    r_items <= r_items + 32'd1;
                end
                if (emit) begin
                    if (WCW'(r_ox) + WCW'(1) >= w_eff) begin
                        r_ox    <= '0;
                        r_oy    <= r_oy + 16'd1;
                        r_oslot <= (32'(r_oslot) == RING - 1) ? '0 : r_oslot + SB'(1);
                    end else begin
                        r_ox <= r_ox + CW'(1);
                    end
                end
            end
        end
    end

    // latch the position of the pixel to compute
    always_ff @(posedge i_clk) begin
        if (acc_in && emit) begin
            r_cx    <= r_ox;
            r_cy    <= r_oy;
            r_cslot <= r_oslot;
            r_fe    <= fe;
        end
    end

    // read address for the vertical pass
    assign neg_r = -$signed({1'b0, r_eff});
    assign pos_r = $signed({1'b0, r_eff});

    always_comb begin
        xi     = $signed(20'(r_cx)) + 20'(r_dx);
        yi     = $signed(20'(r_cy)) + 20'(r_dy);
        cxm    = mirror(xi, $signed(20'(w_eff)));
        rym    = mirror(yi, $signed(20'(h_eff)));
        dyr    = rym - $signed(20'(r_cy));
        slot_s = $signed({2'b00, r_cslot}) + $signed(dyr[SB+1:0]);
        if (slot_s < 0) begin
            slot_s = slot_s + $signed((SB+2)'(RING));
        end else if (slot_s >= $signed((SB+2)'(RING))) begin
            slot_s = slot_s - $signed((SB+2)'(RING));
        end
        mem_raddr = {slot_s[SB-1:0], cxm[CW-1:0]};
        dy_abs    = (r_dy < 0) ? DB'(-r_dy) : DB'(r_dy);
        dx_abs    = (r_dx < 0) ? DB'(-r_dx) : DB'(r_dx);
        dx_off    = $signed({r_dx[DB-1], r_dx}) + $signed({2'b00, r_eff});
    end

    assign issue_v   = (r_state == S_VERT);
    assign issue_h   = (r_state == S_HORZ);
    assign pipe_idle = !r_p.vld && !mac_done;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_dx    <= '0;
            r_dy    <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in && emit) begin
                        r_dx    <= neg_r;
                        r_dy    <= neg_r;
                        r_state <= S_VERT;
                    end
                end
                S_VERT: begin
                    if (r_dy == pos_r) begin
                        r_dy <= neg_r;
                        if (r_dx == pos_r) begin
                            r_state <= S_VDRAIN;
                        end else begin
                            r_dx <= r_dx + DB'(1);
                        end
                    end else begin
                        r_dy <= r_dy + DB'(1);
                    end
                end
                S_VDRAIN: begin
                    if (pipe_idle) begin
                        r_dx    <= neg_r;
                        r_state <= S_HORZ;
                    end
                end
                S_HORZ: begin
                    if (r_dx == pos_r) begin
                        r_state <= S_HDRAIN;
                    end else begin
                        r_dx <= r_dx + DB'(1);
                    end
                end
                S_HDRAIN: begin
                    if (pipe_idle) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // issue stage: operand control into the MAC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
        end else begin
            r_p.vld   <= issue_v || issue_h;
            r_p.first <= issue_v ? (r_dy == neg_r) : (r_dx == neg_r);
            r_p.last  <= issue_v ? (r_dy == pos_r) : (r_dx == pos_r);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_h   <= issue_h;
        r_p_idx <= WIB'(dx_off);
        r_p_tap <= tap_sel(r_taps_lo, r_taps_hi,
                           TAP_IDX_BITS'(issue_v ? dy_abs : dx_abs));
        r_p_win <= r_win[WIB'(dx_off)];
        r_q_h   <= r_p_h;
        r_q_idx <= r_p_idx;
    end

    assign mac_data = r_p_h ? r_p_win : r_rd_data;

    gbl_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_p),
        .i_tap   (r_p_tap),
        .i_data  (mac_data),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    // store vertical sums in the window, keep the horizontal sum
    always_ff @(posedge i_clk) begin
        if (mac_done) begin
            if (r_q_h) begin
                r_res <= mac_sum;
            end else begin
                r_win[r_q_idx] <= mac_sum;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ovld || m_axis_tready)) begin
            r_odata <= r_res;
            r_olast <= r_fe;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = TDW'(r_odata);
    assign m_axis_tlast  = r_olast;

endmodule

[design/gbl_mac.sv]
module gbl_mac #(
    parameter int unsigned PIXEL_BITS = 16,
    parameter int unsigned MAX_RADIUS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbl_pkg::t_mac_ctl             i_ctl,
    input  logic [gbl_pkg::TAP_BITS-1:0]  i_tap,
    input  logic [PIXEL_BITS-1:0]         i_data,
    output logic                          o_done,
    output logic [PIXEL_BITS-1:0]         o_sum
);
    import gbl_pkg::*;

    localparam int unsigned AB = TAP_BITS + PIXEL_BITS + $clog2(2*MAX_RADIUS+2);
    localparam logic [AB:0] PIX_MAX = (AB+1)'((64'd1 << PIXEL_BITS) - 64'd1);
    localparam logic [AB:0] HALF    = (AB+1)'(64'd1 << (TAP_BITS-1));

    logic [AB-1:0]                  r_acc;
    logic                           r_done;
    logic [TAP_BITS+PIXEL_BITS-1:0] prod;
    logic [AB:0]                    rnd;

    assign prod = i_tap * i_data;

    // accumulate one product per cycle while i_ctl.vld is high, restart on the first term
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_acc <= (i_ctl.first ? '0 : r_acc) + AB'(prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.vld && i_ctl.last;
        end
    end

    // round half up and saturate to the pixel range
    assign rnd    = ((AB+1)'(r_acc) + HALF) >> TAP_BITS;
    assign o_sum  = (rnd > PIX_MAX) ? PIX_MAX[PIXEL_BITS-1:0] : rnd[PIXEL_BITS-1:0];
    assign o_done = r_done;

endmodule

[tb/blur_checker.sv]
module blur_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import gbl_pkg::*;

    localparam int RING = 2 * MAX_RADIUS_DEF + 2;
    localparam int MAXW = MAX_WIDTH_DEF;

    typedef struct {
        logic [15:0] pixel;
        logic        frame_end;
    } t_blurred;

    // shadow copy of the register file
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  radius_reg;
    logic [63:0] taps_lo;
    logic [63:0] taps_hi;

    // shadow copy of the frame state
    logic [15:0] ring_rows [0:RING*MAXW-1];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned seen_count;

    t_blurred expected_pixels[$];
    int       fail_count;
    int       pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic longint unsigned coef(longint k);
        longint m;
        m = (k < 0) ? -k : k;
        if (m < 4) return (taps_lo >> (16 * m)) & 64'hFFFF;
        if (m < 8) return (taps_hi >> (16 * (m - 4))) & 64'hFFFF;
        return 0;
    endfunction

    function automatic longint reflect(longint i, longint n);
        longint j;
        j = (i < 0) ? -i : i;
        if (j > n - 1) j = 2 * (n - 1) - j;
        if (j < 0) j = 0;
        if (j > n - 1) j = n - 1;
        return j;
    endfunction

    function automatic longint unsigned round_clip(longint unsigned acc);
        longint unsigned v;
        v = (acc + 64'h8000) >> 16;
        return (v > 64'hFFFF) ? 64'hFFFF : v;
    endfunction

    // advance the frame state by one input and queue any blurred pixel it yields
    task automatic predict_blurred(logic [15:0] value, logic pad);
        longint w, h, r, n, lag, o, y, x, cx, ry;
        longint unsigned acc;
        longint unsigned vsum [0:2*MAX_RADIUS_DEF];
        t_blurred res;
        w = width_reg;
        h = height_reg;
        r = radius_reg;
        if (w < 8) w = 8;
        if (w > MAXW) w = MAXW;
        if (h < 8) h = 8;
        if (r < 1) r = 1;
        if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;

        // store the pixel while the frame still has rows to fill
        if (row_pos < h) begin
            ring_rows[(row_pos % RING) * MAXW + (col_pos % MAXW)] = pad ? 16'd0 : value;
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
        end

        n = seen_count;
        if (seen_count != 32'hFFFF_FFFF) seen_count++;
        lag = r * w + r;
        if (n < lag) return;
        o = n - lag;
        y = o / w;
        x = o % w;

        // vertical sums per column, then the horizontal sum over them
        for (longint dx = -r; dx <= r; dx++) begin
            cx  = reflect(x + dx, w);
            acc = 0;
            for (longint dy = -r; dy <= r; dy++) begin
                ry  = reflect(y + dy, h);
                acc += coef(dy) * ring_rows[(ry % RING) * MAXW + cx];
            end
            vsum[dx + r] = round_clip(acc);
        end
        acc = 0;
        for (longint dx = -r; dx <= r; dx++) acc += coef(dx) * vsum[dx + r];

        res.pixel     = 16'(round_clip(acc));
        res.frame_end = 1'b0;
        if (o >= w * h - 1) begin
            res.frame_end = 1'b1;
            col_pos    = 0;
            row_pos    = 0;
            seen_count = 0;
        end
        expected_pixels.push_back(res);
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
        for (int i = 0; i < RING * MAXW; i++) ring_rows[i] = '0;
    end

    always @(posedge i_clk) begin
        t_blurred want;
        if (!i_rst_n) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            radius_reg <= RADIUS_RST;
            taps_lo    <= '0;
            taps_hi    <= '0;
            col_pos    = 0;
            row_pos    = 0;
            seen_count = 0;
        end else begin
            // track register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= i_cfg_data[10:0];
                    CFG_IMAGE_HEIGHT: height_reg <= i_cfg_data[15:0];
                    CFG_BLUR_RADIUS:  radius_reg <= i_cfg_data[2:0];
                    CFG_TAPS_LO:      taps_lo    <= i_cfg_data;
                    CFG_TAPS_HI:      taps_hi    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) predict_blurred(s_axis_tdata, s_axis_tuser);
            // compare each output transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected output transaction: pixel %0h last %0b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== want.pixel) begin
                        $error("blurred_pixel: expected %0h actual %0h", want.pixel, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("is_frame_end: expected %0b actual %0b",
                               want.frame_end, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_pixels.size();
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import gbl_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int     fail_count;
    int     pending;
    int     items_sent;
    longint cycle_count;
    bit     calm;

    separable_gaussian_blur_2d dut (.*);

    blur_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int gap_draw();
        return (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    endfunction

    // receiver: stall a random number of cycles before each output transaction
    initial begin
        int k;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            k = gap_draw();
            if (k > 0) begin
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] value, logic pad);
        int k;
        k = gap_draw();
        if (k > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (k) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= pad;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pixel_draw(int mode);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return (mode == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // configure, then stream one frame plus its flush items
    task automatic run_frame(int w, int h, int r, int tap_mode, bit hold_mid);
        logic [63:0] lo, hi;
        logic [15:0] t;
        int npix, nflush;
        for (int k = 0; k < 8; k++) begin
            if (tap_mode == 0) t = '0;
            else if (tap_mode == 1) t = 16'($urandom_range(0, 65535));
            else if (k <= r) t = 16'($urandom_range(0, 65536 / (2 * r + 1)));
            else t = 16'($urandom_range(0, 65535));
            if (k < 4) lo[16*k +: 16] = t;
            else hi[16*(k-4) +: 16] = t;
        end
        write_reg(CFG_IMAGE_WIDTH, 64'(w));
        write_reg(CFG_IMAGE_HEIGHT, 64'(h));
        write_reg(CFG_BLUR_RADIUS, 64'(r));
        write_reg(CFG_TAPS_LO, lo);
        write_reg(CFG_TAPS_HI, hi);
        // clamped sizes as the block uses them
        if (w < 8) w = 8;
        if (h < 8) h = 8;
        if (r < 1) r = 1;
        npix   = w * h;
        nflush = r * w + r;
        for (int i = 0; i < npix; i++) begin
            // hold off until the pipeline is empty once, mid frame
            if (hold_mid && i == npix / 2) drain();
            send_pixel(pixel_draw(tap_mode), $urandom_range(0, 15) == 0);
        end
        // flush items, some of them disguised as pixels
        for (int i = 0; i < nflush; i++)
            send_pixel(16'($urandom_range(0, 65535)), $urandom_range(0, 7) != 0);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cycle_count   = 0;
        items_sent    = 0;
        calm          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, largest radius, clamping, zero and saturating taps
        run_frame(8, 8, 1, 2, 1'b0);
        run_frame(8, 8, 7, 2, 1'b1);
        run_frame(3, 0, 0, 2, 1'b0);
        run_frame(8, 8, 2, 0, 1'b0);
        run_frame(9, 8, 3, 1, 1'b0);
        // large register values, replaced before any pixel flows
        write_reg(CFG_IMAGE_WIDTH, 64'h7FF);
        write_reg(CFG_IMAGE_HEIGHT, 64'hFFFF);
        write_reg(CFG_BLUR_RADIUS, 64'h7);
        write_reg(CFG_TAPS_LO, '1);
        write_reg(CFG_TAPS_HI, '1);

        // random frames, some without idling
        while (items_sent < 1150) begin
            calm = ($urandom_range(0, 3) == 0);
            run_frame($urandom_range(8, 14), $urandom_range(8, 10), $urandom_range(1, 7),
                      ($urandom_range(0, 5) == 0) ? 1 : 2, 1'b0);
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
